// File: rtl/catmull_rom_path_sampler_top_assert.svh
// ----------------------------------------------------------------------------
// Catmull-Rom path sampler assertion macros
// Shared property forms for the checker of the path sampler.
// ----------------------------------------------------------------------------
`ifndef CATMULL_ROM_PATH_SAMPLER_TOP_ASSERT_SVH
`define CATMULL_ROM_PATH_SAMPLER_TOP_ASSERT_SVH

// Same-cycle implication, disabled while reset is high.
`define CRPS_ASSERT_NOW(name, clk, rst, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled while reset is high.
`define CRPS_ASSERT_NEXT(name, clk, rst, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

// Next-cycle implication that is also checked across reset.
`define CRPS_ASSERT_NEXT_ALWAYS(name, clk, ante, cons, msg) \
  name: assert property (@(posedge clk) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: rtl/crps_pkg.sv
// ----------------------------------------------------------------------------
// Catmull-Rom path sampler package
// Sequencer states, arithmetic unit controls and fixed constants.
// ----------------------------------------------------------------------------
`default_nettype none

package crps_pkg;

  // Width and reset value of the samples-between register.
  localparam int CFG_W = 5;
  localparam logic [CFG_W-1:0] SB_RESET = 5'd7;

  // Four blend terms per coordinate, three coordinates per sample.
  localparam int NUM_TERMS  = 4;
  localparam int NUM_COORDS = 3;

  // Sequencer states.
  typedef enum logic [3:0] {
    ST_IDLE,
    ST_SETUP_SQ,
    ST_SETUP_CUBE,
    ST_KNOT,
    ST_COEF,
    ST_MUL,
    ST_DIV_LOAD,
    ST_DIV,
    ST_DIV_DONE,
    ST_SAMPLE_OUT,
    ST_END_OUT,
    ST_FINISH
  } state_t;

  // Controls from the sequencer to the shared multiply/divide unit.
  typedef struct packed {
    logic mul_en;
    logic acc_clear;
    logic acc_add;
    logic div_load;
    logic div_step;
  } unit_ctrl_t;

endpackage

`default_nettype wire

// File: rtl/crps_unit.sv
// ----------------------------------------------------------------------------
// Catmull-Rom path sampler arithmetic unit
// One signed multiplier with an accumulator, followed by a bit-serial divider
// that rounds the blend sum by 2*D^3 and saturates to the coordinate range.
// ----------------------------------------------------------------------------
`default_nettype none

module crps_unit #(
  parameter int COORD_WIDTH = 32,
  parameter int D_WIDTH     = 5
) (
  input  wire logic                            clk,
  input  wire crps_pkg::unit_ctrl_t            ctrl,
  input  wire logic signed [3*D_WIDTH+1:0]     coef,
  input  wire logic signed [COORD_WIDTH:0]     operand,
  input  wire logic        [3*D_WIDTH-1:0]     d3,
  output logic signed      [COORD_WIDTH-1:0]   result
);

  localparam int CF_W   = 3*D_WIDTH + 2;
  localparam int PROD_W = CF_W + COORD_WIDTH + 1;
  localparam int ACC_W  = COORD_WIDTH + 3*D_WIDTH + 4;
  localparam int VW     = 3*D_WIDTH + 1;
  localparam int HI_W   = ACC_W - (COORD_WIDTH - 1);

  logic signed [PROD_W-1:0]      prod;
  logic signed [ACC_W-1:0]       acc;
  logic        [ACC_W-1:0]       mag;
  logic        [HI_W-1:0]        hi;
  logic        [VW-1:0]          dv;
  logic        [VW-1:0]          rem;
  logic        [VW:0]            rem2;
  logic                          ge;
  logic        [COORD_WIDTH-2:0] sh;
  logic                          neg;
  logic                          ovf;
  logic        [COORD_WIDTH-1:0] u;

  // Divisor is twice the cube of the step count.
  assign dv = {d3, 1'b0};

  // Floor division of a negative sum goes through its ones' complement.
  assign mag = acc[ACC_W-1] ? ~acc : acc;
  assign hi  = mag[ACC_W-1:COORD_WIDTH-1];

  // One restoring step: bring down the next dividend bit and try a subtract.
  assign rem2 = {rem, sh[COORD_WIDTH-2]};
  assign ge   = rem2 >= {1'b0, dv};

  // Multiply and accumulate, one blend term per cycle.
  always_ff @(posedge clk) begin
    if (ctrl.mul_en) begin
      prod <= coef * operand;
    end
    if (ctrl.acc_clear) begin
      acc <= signed'(ACC_W'(d3));
    end else if (ctrl.acc_add) begin
      acc <= acc + ACC_W'(prod);
    end
  end

  // Divider: the high part decides saturation, the low part is shifted through.
  always_ff @(posedge clk) begin
    if (ctrl.div_load) begin
      neg <= acc[ACC_W-1];
      ovf <= hi >= HI_W'(dv);
      rem <= hi[VW-1:0];
      sh  <= mag[COORD_WIDTH-2:0];
    end else if (ctrl.div_step) begin
      rem <= ge ? VW'(rem2 - {1'b0, dv}) : rem2[VW-1:0];
      sh  <= {sh[COORD_WIDTH-3:0], ge};
    end
  end

  // Map the unsigned quotient back to a signed, saturated coordinate.
  assign u = {1'b0, sh};

  always_comb begin
    if (ovf) begin
      result = neg ? {1'b1, {(COORD_WIDTH-1){1'b0}}} : {1'b0, {(COORD_WIDTH-1){1'b1}}};
    end else begin
      result = neg ? ~u : u;
    end
  end

endmodule

`default_nettype wire

// File: rtl/catmull_rom_path_sampler_top.sv
// ----------------------------------------------------------------------------
// Catmull-Rom path sampler
// Samples a uniform Catmull-Rom spline through a stream of 3D control points.
// ----------------------------------------------------------------------------
// Control points enter one per input transfer and the block keeps the last
// three. From the fourth point of a path on, each point produces one segment:
// a copy of the older inner point, then N Hermite-blended samples, and on the
// path's last point also the second-to-last point; the last point always
// clears the window. One input item is worked at a time and in_ready is low
// until its results are all handed to the output register. Each coordinate of
// each sample runs its blend terms on the shared multiplier and then goes
// through the bit-serial divider, which sets the rate; a segment also waits
// on any output stall and, on the path's last point, on the closing point.
// ----------------------------------------------------------------------------
`default_nettype none

module catmull_rom_path_sampler_top #(
  parameter int COORD_WIDTH = 32,
  parameter int MAX_SAMPLES = 30
) (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic                          cfg_valid,
  output logic                               cfg_ready,
  input  wire logic [crps_pkg::CFG_W-1:0]    samples_between,
  input  wire logic                          in_valid,
  output logic                               in_ready,
  input  wire logic signed [COORD_WIDTH-1:0] px,
  input  wire logic signed [COORD_WIDTH-1:0] py,
  input  wire logic signed [COORD_WIDTH-1:0] pz,
  input  wire logic                          last_point,
  output logic                               out_valid,
  input  wire logic                          out_ready,
  output logic signed [COORD_WIDTH-1:0]      qx,
  output logic signed [COORD_WIDTH-1:0]      qy,
  output logic signed [COORD_WIDTH-1:0]      qz,
  output logic                               is_knot,
  output logic                               end_of_run,
  output logic                               end_of_path
);

  localparam int DW    = $clog2(MAX_SAMPLES + 2);
  localparam int D2W   = 2*DW;
  localparam int D3W   = 3*DW;
  localparam int EW    = 2*DW + 1;
  localparam int CF_W  = 3*DW + 2;
  localparam int TW    = 3*DW + 4;
  localparam int CNT_W = $clog2(COORD_WIDTH);

  crps_pkg::state_t       state;
  crps_pkg::state_t       state_next;
  crps_pkg::unit_ctrl_t   ctrl;

  logic [crps_pkg::CFG_W-1:0] sb;
  logic [1:0]                 points_seen;
  logic                       out_free;
  logic                       out_load;

  // Point window (oldest first) and the incoming point, per coordinate.
  logic signed [COORD_WIDTH-1:0] win [3][3];
  logic signed [COORD_WIDTH-1:0] p3  [3];
  logic signed [COORD_WIDTH-1:0] res [3];
  logic                          last_q;

  // Step counts and running powers for the Hermite weights.
  logic [DW-1:0]  ns;
  logic [DW-1:0]  ns_in;
  logic [DW-1:0]  d;
  logic [D2W-1:0] d2;
  logic [D3W-1:0] d3;
  logic [DW-1:0]  k;
  logic [D2W-1:0] k2;
  logic [D3W-1:0] k3;
  logic [D3W-1:0] k2d;
  logic [D3W-1:0] kd2;
  logic [EW-1:0]  e;

  logic signed [TW-1:0]   t_k3;
  logic signed [TW-1:0]   t_k2d;
  logic signed [TW-1:0]   t_kd2;
  logic signed [TW-1:0]   t_d3;
  logic signed [TW-1:0]   c1t;
  logic signed [TW-1:0]   c2t;
  logic signed [TW-1:0]   c3t;
  logic signed [TW-1:0]   c4t;
  logic signed [CF_W-1:0] c1x2;
  logic signed [CF_W-1:0] c2x2;
  logic signed [CF_W-1:0] c3;
  logic signed [CF_W-1:0] c4;

  logic [1:0]       ci;
  logic [2:0]       ti;
  logic [CNT_W-1:0] cnt;

  logic signed [CF_W-1:0]        coef;
  logic signed [COORD_WIDTH:0]   operand;
  logic signed [COORD_WIDTH-1:0] op_p0;
  logic signed [COORD_WIDTH-1:0] op_p1;
  logic signed [COORD_WIDTH-1:0] op_p2;
  logic signed [COORD_WIDTH-1:0] op_p3;
  logic signed [COORD_WIDTH-1:0] unit_result;

  // The register can always take a write.
  assign cfg_ready = 1'b1;

  // The output register frees up when its result transfers.
  assign out_free = !out_valid || out_ready;

  // Clamp the sample count to what the datapath is sized for.
  assign ns_in = (int'(sb) > MAX_SAMPLES) ? DW'(MAX_SAMPLES) : DW'(sb);

  // Next state.
  always_comb begin
    state_next = state;
    unique case (state)
      crps_pkg::ST_IDLE: begin
        if (in_valid) begin
          state_next = (points_seen == 2'd3) ? crps_pkg::ST_SETUP_SQ : crps_pkg::ST_FINISH;
        end
      end
      crps_pkg::ST_SETUP_SQ:   state_next = crps_pkg::ST_SETUP_CUBE;
      crps_pkg::ST_SETUP_CUBE: state_next = crps_pkg::ST_KNOT;
      crps_pkg::ST_KNOT: begin
        if (out_free) begin
          if (ns != '0) begin
            state_next = crps_pkg::ST_COEF;
          end else begin
            state_next = last_q ? crps_pkg::ST_END_OUT : crps_pkg::ST_FINISH;
          end
        end
      end
      crps_pkg::ST_COEF: state_next = crps_pkg::ST_MUL;
      crps_pkg::ST_MUL: begin
        if (ti == 3'(crps_pkg::NUM_TERMS)) begin
          state_next = crps_pkg::ST_DIV_LOAD;
        end
      end
      crps_pkg::ST_DIV_LOAD: state_next = crps_pkg::ST_DIV;
      crps_pkg::ST_DIV: begin
        if (cnt == '0) begin
          state_next = crps_pkg::ST_DIV_DONE;
        end
      end
      crps_pkg::ST_DIV_DONE: begin
        state_next = (ci == 2'(crps_pkg::NUM_COORDS - 1)) ? crps_pkg::ST_SAMPLE_OUT
                                                           : crps_pkg::ST_MUL;
      end
      crps_pkg::ST_SAMPLE_OUT: begin
        if (out_free) begin
          if (k != ns) begin
            state_next = crps_pkg::ST_COEF;
          end else begin
            state_next = last_q ? crps_pkg::ST_END_OUT : crps_pkg::ST_FINISH;
          end
        end
      end
      crps_pkg::ST_END_OUT: begin
        if (out_free) begin
          state_next = crps_pkg::ST_FINISH;
        end
      end
      crps_pkg::ST_FINISH: state_next = crps_pkg::ST_IDLE;
      default:             state_next = crps_pkg::ST_IDLE;
    endcase
  end

  // Sequencer outputs.
  always_comb begin
    in_ready       = 1'b0;
    out_load       = 1'b0;
    ctrl           = '0;
    unique case (state) inside
      crps_pkg::ST_IDLE: in_ready = 1'b1;
      crps_pkg::ST_KNOT, crps_pkg::ST_SAMPLE_OUT, crps_pkg::ST_END_OUT: begin
        out_load = out_free;
      end
      crps_pkg::ST_MUL: begin
        ctrl.mul_en    = ti != 3'(crps_pkg::NUM_TERMS);
        ctrl.acc_clear = ti == '0;
        ctrl.acc_add   = ti != '0;
      end
      crps_pkg::ST_DIV_LOAD: ctrl.div_load = 1'b1;
      crps_pkg::ST_DIV:      ctrl.div_step = 1'b1;
      default: ;
    endcase
  end

  // Control registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= crps_pkg::ST_IDLE;
      sb          <= crps_pkg::SB_RESET;
      points_seen <= '0;
      out_valid   <= 1'b0;
    end else begin
      state <= state_next;
      if (cfg_valid) begin
        sb <= samples_between;
      end
      if (state == crps_pkg::ST_FINISH) begin
        if (last_q) begin
          points_seen <= '0;
        end else if (points_seen != 2'd3) begin
          points_seen <= points_seen + 2'd1;
        end
      end
      if (out_load) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // Hermite weights for the current k, as exact multiples of 1/D^3.
  assign t_k3  = signed'(TW'(k3));
  assign t_k2d = signed'(TW'(k2d));
  assign t_kd2 = signed'(TW'(kd2));
  assign t_d3  = signed'(TW'(d3));
  assign c1t   = (t_k3 <<< 1) - t_k2d - (t_k2d <<< 1) + t_d3;
  assign c2t   = t_k2d + (t_k2d <<< 1) - (t_k3 <<< 1);
  assign c3t   = t_k3 - (t_k2d <<< 1) + t_kd2;
  assign c4t   = t_k3 - t_k2d;

  // Operand selection for the shared multiplier.
  assign op_p0 = win[ci][0];
  assign op_p1 = win[ci][1];
  assign op_p2 = win[ci][2];
  assign op_p3 = p3[ci];

  always_comb begin
    case (ti)
      3'd0: begin
        coef    = c1x2;
        operand = (COORD_WIDTH+1)'(op_p1);
      end
      3'd1: begin
        coef    = c2x2;
        operand = (COORD_WIDTH+1)'(op_p2);
      end
      3'd2: begin
        coef    = c3;
        operand = (COORD_WIDTH+1)'(op_p2) - (COORD_WIDTH+1)'(op_p0);
      end
      3'd3: begin
        coef    = c4;
        operand = (COORD_WIDTH+1)'(op_p3) - (COORD_WIDTH+1)'(op_p1);
      end
      default: begin
        coef    = '0;
        operand = '0;
      end
    endcase
  end

  crps_unit #(
    .COORD_WIDTH (COORD_WIDTH),
    .D_WIDTH     (DW)
  ) u_unit (
    .clk     (clk),
    .ctrl    (ctrl),
    .coef    (coef),
    .operand (operand),
    .d3      (d3),
    .result  (unit_result)
  );

  // Datapath registers stepped by the sequencer.
  always_ff @(posedge clk) begin
    unique case (state)
      crps_pkg::ST_IDLE: begin
        if (in_valid) begin
          p3[0]  <= px;
          p3[1]  <= py;
          p3[2]  <= pz;
          last_q <= last_point;
          ns     <= ns_in;
          d      <= ns_in + DW'(1);
        end
      end
      crps_pkg::ST_SETUP_SQ: begin
        d2 <= D2W'(d) * D2W'(d);
      end
      crps_pkg::ST_SETUP_CUBE: begin
        d3  <= D3W'(d2) * D3W'(d);
        k   <= DW'(1);
        k2  <= D2W'(1);
        k3  <= D3W'(1);
        k2d <= D3W'(d);
        kd2 <= D3W'(d2);
        e   <= EW'({d, 1'b0}) + EW'(d);
      end
      crps_pkg::ST_COEF: begin
        c1x2 <= {c1t[CF_W-2:0], 1'b0};
        c2x2 <= {c2t[CF_W-2:0], 1'b0};
        c3   <= c3t[CF_W-1:0];
        c4   <= c4t[CF_W-1:0];
        ci   <= '0;
        ti   <= '0;
      end
      crps_pkg::ST_MUL: begin
        ti <= ti + 3'd1;
      end
      crps_pkg::ST_DIV_LOAD: begin
        cnt <= CNT_W'(COORD_WIDTH - 2);
      end
      crps_pkg::ST_DIV: begin
        cnt <= cnt - CNT_W'(1);
      end
      crps_pkg::ST_DIV_DONE: begin
        res[ci] <= unit_result;
        ci      <= ci + 2'd1;
        ti      <= '0;
      end
      crps_pkg::ST_SAMPLE_OUT: begin
        // Advance the running powers by forward differences.
        if (out_free && (k != ns)) begin
          k3  <= k3 + D3W'({k2, 1'b0}) + D3W'(k2) + D3W'({k, 1'b0}) + D3W'(k) + D3W'(1);
          k2  <= k2 + D2W'({k, 1'b0}) + D2W'(1);
          k2d <= k2d + D3W'(e);
          e   <= e + EW'({d, 1'b0});
          kd2 <= kd2 + D3W'(d2);
          k   <= k + DW'(1);
        end
      end
      crps_pkg::ST_FINISH: begin
        if (!last_q) begin
          for (int c = 0; c < crps_pkg::NUM_COORDS; c++) begin
            win[c][0] <= win[c][1];
            win[c][1] <= win[c][2];
            win[c][2] <= p3[c];
          end
        end
      end
      default: ;
    endcase
  end

  // Output register payload.
  always_ff @(posedge clk) begin
    if (out_load) begin
      case (state)
        crps_pkg::ST_KNOT: begin
          qx          <= win[0][1];
          qy          <= win[1][1];
          qz          <= win[2][1];
          is_knot     <= 1'b1;
          end_of_run  <= (ns == '0) && !last_q;
          end_of_path <= 1'b0;
        end
        crps_pkg::ST_SAMPLE_OUT: begin
          qx          <= res[0];
          qy          <= res[1];
          qz          <= res[2];
          is_knot     <= 1'b0;
          end_of_run  <= (k == ns) && !last_q;
          end_of_path <= 1'b0;
        end
        default: begin
          qx          <= win[0][2];
          qy          <= win[1][2];
          qz          <= win[2][2];
          is_knot     <= 1'b1;
          end_of_run  <= 1'b1;
          end_of_path <= 1'b1;
        end
      endcase
    end
  end

endmodule

`default_nettype wire

// File: rtl/crps_checker.sv
// ----------------------------------------------------------------------------
// Catmull-Rom path sampler checker
// Port-level properties of the path sampler, attached by bind.
// ----------------------------------------------------------------------------
`default_nettype none

`include "catmull_rom_path_sampler_top_assert.svh"

module crps_checker #(
  parameter int COORD_WIDTH = 32
) (
  input wire logic                   clk,
  input wire logic                   rst,
  input wire logic                   in_valid,
  input wire logic                   in_ready,
  input wire logic                   out_valid,
  input wire logic                   out_ready,
  input wire logic [COORD_WIDTH-1:0] qx,
  input wire logic                   is_knot,
  input wire logic                   end_of_run,
  input wire logic                   end_of_path
);

  // Reset leaves the block empty and ready for a point.
  `CRPS_ASSERT_NEXT_ALWAYS(a_reset_empty, clk, rst, !out_valid && in_ready, "reset state wrong")

  // A point is worked alone: after its transfer the input closes.
  `CRPS_ASSERT_NEXT(a_one_item, clk, rst, in_valid && in_ready, !in_ready, "input not closed")

  // The closing sample of a path is a knot and ends the run.
  `CRPS_ASSERT_NOW(a_path_end, clk, rst, out_valid && end_of_path, is_knot && end_of_run, "bad path end")

  // A stalled result holds its value.
  `CRPS_ASSERT_NEXT(a_out_hold, clk, rst, out_valid && !out_ready, out_valid && $stable(qx) && $stable(end_of_run), "stalled result changed")

endmodule

bind catmull_rom_path_sampler_top crps_checker #(
  .COORD_WIDTH (COORD_WIDTH)
) u_crps_checker (
  .clk         (clk),
  .rst         (rst),
  .in_valid    (in_valid),
  .in_ready    (in_ready),
  .out_valid   (out_valid),
  .out_ready   (out_ready),
  .qx          (qx),
  .is_knot     (is_knot),
  .end_of_run  (end_of_run),
  .end_of_path (end_of_path)
);

`default_nettype wire
